@@ design/walu_pkg.sv @@
// ----------------------------------------------------------------------------
// walu_pkg
// Shared types and codes for the 16-bit ALU with status flags.
// ----------------------------------------------------------------------------
package walu_pkg;

    localparam logic [5:0] OP_A    = 6'd0;
    localparam logic [5:0] OP_AB   = 6'd1;
    localparam logic [5:0] OP_ABS  = 6'd2;
    localparam logic [5:0] OP_AND  = 6'd3;
    localparam logic [5:0] OP_C    = 6'd4;
    localparam logic [5:0] OP_CB   = 6'd5;
    localparam logic [5:0] OP_COC  = 6'd6;
    localparam logic [5:0] OP_CZC  = 6'd7;
    localparam logic [5:0] OP_DEC  = 6'd8;
    localparam logic [5:0] OP_DECT = 6'd9;
    localparam logic [5:0] OP_INC  = 6'd10;
    localparam logic [5:0] OP_INCT = 6'd11;
    localparam logic [5:0] OP_INV  = 6'd12;
    localparam logic [5:0] OP_MOV  = 6'd13;
    localparam logic [5:0] OP_MOVB = 6'd14;
    localparam logic [5:0] OP_NEG  = 6'd15;
    localparam logic [5:0] OP_OR   = 6'd16;
    localparam logic [5:0] OP_S    = 6'd17;
    localparam logic [5:0] OP_SB   = 6'd18;
    localparam logic [5:0] OP_SLA  = 6'd19;
    localparam logic [5:0] OP_SOC  = 6'd20;
    localparam logic [5:0] OP_SOCB = 6'd21;
    localparam logic [5:0] OP_SRA  = 6'd22;
    localparam logic [5:0] OP_SRC  = 6'd23;
    localparam logic [5:0] OP_SRL  = 6'd24;
    localparam logic [5:0] OP_SZC  = 6'd25;
    localparam logic [5:0] OP_SZCB = 6'd26;
    localparam logic [5:0] OP_XOR  = 6'd27;
    localparam logic [5:0] OP_CLR  = 6'd28;
    localparam logic [5:0] OP_SETO = 6'd29;
    localparam logic [5:0] OP_SWPB = 6'd30;
    localparam logic [5:0] OP_LDST = 6'd31;
    localparam logic [5:0] OP_RDST = 6'd32;
    localparam logic [5:0] OP_JMP  = 6'd33;
    localparam logic [5:0] OP_JEQ  = 6'd34;
    localparam logic [5:0] OP_JNE  = 6'd35;

    localparam int FLG_LGT = 15;
    localparam int FLG_AGT = 14;
    localparam int FLG_EQU = 13;
    localparam int FLG_CRY = 12;
    localparam int FLG_OVF = 11;
    localparam int FLG_PAR = 10;

    typedef struct packed {
        logic [5:0]  op;
        logic [15:0] first_operand;
        logic [15:0] second_operand;
        logic [3:0]  shift_count;
    } walu_req_t;

    typedef struct packed {
        logic [15:0] result;
        logic        write_back;
        logic [15:0] status_out;
        logic        jump_taken;
    } walu_rsp_t;

endpackage

@@ design/walu_core.sv @@
// ----------------------------------------------------------------------------
// walu_core
// Combinational ALU datapath: adder, comparator, barrel shifter and flag logic.
// ----------------------------------------------------------------------------
module walu_core (
    input  walu_pkg::walu_req_t req,
    input  logic [15:0]         status_in,
    output walu_pkg::walu_rsp_t rsp
);
    import walu_pkg::*;

    function automatic logic [15:0] res_flags(logic [15:0] st, logic [15:0] r);
        logic [15:0] s;
        s = st;
        s[FLG_EQU] = (r == 16'h0000);
        s[FLG_LGT] = (r != 16'h0000);
        s[FLG_AGT] = (r != 16'h0000) && !r[15];
        return s;
    endfunction

    logic [15:0] a, b;
    logic [3:0]  cnt;
    logic [15:0] add_x, add_y;
    logic [16:0] add_sum;
    logic [15:0] add_st;
    logic [15:0] cmp_x, cmp_y, cmp_diff;
    logic [15:0] cmp_st;
    logic [16:0] sl;
    logic [16:0] srl_v;
    logic [16:0] sra_v;
    logic [31:0] src_v;
    logic        sla_ovf;
    logic [15:0] neg_b;
    logic [15:0] st;
    logic [15:0] r;
    logic [7:0]  rb;
    logic        wb;
    logic        jt;

    assign a     = req.first_operand;
    assign b     = req.second_operand;
    assign cnt   = req.shift_count;
    assign neg_b = 16'h0000 - b;

    // adder operand select
    always_comb begin
        add_x = a;
        add_y = b;
        case (req.op)
            OP_AB: begin
                add_x = {a[7:0], 8'h00};
                add_y = {b[7:0], 8'h00};
            end
            OP_SB: begin
                add_x = {a[7:0], 8'h00};
                add_y = {neg_b[7:0], 8'h00};
            end
            OP_S:    add_y = neg_b;
            OP_DEC:  add_y = 16'hFFFF;
            OP_DECT: add_y = 16'hFFFE;
            OP_INC:  add_y = 16'h0001;
            OP_INCT: add_y = 16'h0002;
            OP_NEG: begin
                add_x = ~a;
                add_y = 16'h0001;
            end
            default: begin
                add_x = a;
                add_y = b;
            end
        endcase
    end

    assign add_sum = {1'b0, add_x} + {1'b0, add_y};

    always_comb begin
        add_st = res_flags(status_in, add_sum[15:0]);
        add_st[FLG_CRY] = add_sum[16];
        add_st[FLG_OVF] = (add_x[15] == add_y[15]) && (add_sum[15] != add_x[15]);
    end

    // compare
    always_comb begin
        if (req.op == OP_CB) begin
            cmp_x = {a[7:0], 8'h00};
            cmp_y = {b[7:0], 8'h00};
        end else begin
            cmp_x = a;
            cmp_y = b;
        end
    end

    assign cmp_diff = cmp_y - cmp_x;

    always_comb begin
        cmp_st = status_in;
        cmp_st[FLG_EQU] = (cmp_x == cmp_y);
        cmp_st[FLG_LGT] = (cmp_x[15] && !cmp_y[15]) ||
                          ((cmp_x[15] == cmp_y[15]) && cmp_diff[15]);
        cmp_st[FLG_AGT] = (!cmp_x[15] && cmp_y[15]) ||
                          ((cmp_x[15] == cmp_y[15]) && cmp_diff[15]);
    end

    // barrel shifter; bit 0 of the SRL and SRA words is the last bit out
    assign sl    = {1'b0, a} << cnt;
    assign srl_v = {a, 1'b0} >> cnt;
    assign sra_v = 17'($signed({a, 1'b0}) >>> cnt);
    assign src_v = {a, a} >> cnt;

    always_comb begin
        sla_ovf = 1'b0;
        for (int i = 1; i < 16; i++) begin
            if ((i <= int'(cnt)) && (a[15-i] != a[15])) begin
                sla_ovf = 1'b1;
            end
        end
    end

    always_comb begin
        st = status_in;
        r  = 16'h0000;
        rb = 8'h00;
        wb = 1'b1;
        jt = 1'b0;
        case (req.op)
            OP_A, OP_S, OP_DEC, OP_DECT, OP_INC, OP_INCT, OP_NEG: begin
                r  = add_sum[15:0];
                st = add_st;
            end
            OP_AB, OP_SB: begin
                r  = {8'h00, add_sum[15:8]};
                st = add_st;
                st[FLG_PAR] = ^add_sum[15:8];
            end
            OP_ABS: begin
                st = res_flags(status_in, a);
                st[FLG_OVF] = (a == 16'h8000);
                if (a[15]) begin
                    r = 16'h0000 - a;
                end else begin
                    r  = a;
                    wb = 1'b0;
                end
            end
            OP_AND: begin
                r  = a & b;
                st = res_flags(status_in, r);
            end
            OP_OR, OP_SOC: begin
                r  = a | b;
                st = res_flags(status_in, r);
            end
            OP_SZC: begin
                r  = a & ~b;
                st = res_flags(status_in, r);
            end
            OP_SOCB, OP_SZCB: begin
                rb = (req.op == OP_SOCB) ? (a[7:0] | b[7:0]) : (a[7:0] & ~b[7:0]);
                r  = {8'h00, rb};
                st = res_flags(status_in, {rb, 8'h00});
                st[FLG_PAR] = ^rb;
            end
            OP_MOV: begin
                r  = b;
                st = res_flags(status_in, b);
            end
            OP_MOVB: begin
                r  = {8'h00, b[7:0]};
                st = res_flags(status_in, {b[7:0], 8'h00});
            end
            OP_C, OP_CB: begin
                st = cmp_st;
                wb = 1'b0;
            end
            OP_COC: begin
                st[FLG_EQU] = ((b & ~a) == 16'h0000);
                wb = 1'b0;
            end
            OP_CZC: begin
                st[FLG_EQU] = ((b & a) == 16'h0000);
                wb = 1'b0;
            end
            OP_SLA: begin
                r  = sl[15:0];
                st = res_flags(status_in, r);
                st[FLG_OVF] = sla_ovf;
                st[FLG_CRY] = sl[16];
            end
            OP_SRA, OP_SRL, OP_SRC: begin
                if (req.op == OP_SRA) begin
                    r = sra_v[16:1];
                end else if (req.op == OP_SRL) begin
                    r = srl_v[16:1];
                end else begin
                    r = src_v[15:0];
                end
                st = res_flags(status_in, r);
                if (cnt != 4'd0) begin
                    st[FLG_CRY] = srl_v[0];
                end
            end
            OP_INV:  r = ~a;
            OP_XOR:  r = a ^ b;
            OP_CLR:  r = 16'h0000;
            OP_SETO: r = 16'hFFFF;
            OP_SWPB: r = {a[7:0], a[15:8]};
            OP_LDST: begin
                st = b;
                wb = 1'b0;
            end
            OP_RDST: r = status_in;
            OP_JMP: begin
                jt = 1'b1;
                wb = 1'b0;
            end
            OP_JEQ: begin
                jt = status_in[FLG_EQU];
                wb = 1'b0;
            end
            OP_JNE: begin
                jt = !status_in[FLG_EQU];
                wb = 1'b0;
            end
            default: wb = 1'b0;
        endcase
    end

    assign rsp.result     = r;
    assign rsp.write_back = wb;
    assign rsp.status_out = st;
    assign rsp.jump_taken = jt;

endmodule

@@ design/word_alu_with_status_flags.sv @@
// ----------------------------------------------------------------------------
// word_alu_with_status_flags: 16-bit ALU with status word
// A request is accepted into the input reg, then moves to the result reg.
// Throughput 1 request per cycle while m_ready is high; status is updated as
// a request leaves the input reg, so back-to-back requests see it in order.
// Reset (aresetn low, synchronous) empties both stages and clears status.
// ----------------------------------------------------------------------------
module word_alu_with_status_flags (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  walu_pkg::walu_req_t s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output walu_pkg::walu_rsp_t m_data
);
    import walu_pkg::*;

    logic        in_valid_reg;
    walu_req_t   in_data_reg;
    logic        out_valid_reg;
    walu_rsp_t   out_data_reg;
    logic [15:0] status_reg;
    logic [15:0] status_next;
    walu_rsp_t   core_rsp;
    logic        advance;

    walu_core u_core (
        .req       (in_data_reg),
        .status_in (status_reg),
        .rsp       (core_rsp)
    );

    assign advance     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready     = !in_valid_reg || advance;
    assign status_next = advance ? core_rsp.status_out : status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= 16'h0000;
        end else begin
            status_reg <= status_next;
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= core_rsp;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
